// ----- design/ppmfd_pkg.sv -----
// shared constants, types and mapping functions of the ppm frame decoder
package ppmfd_pkg;

	// channel slots in the pulse store
	localparam int NUM_SLOTS = 8;
	localparam int SLOT_W    = $clog2(NUM_SLOTS);
	localparam int CNT_W     = $clog2(NUM_SLOTS + 1);

	localparam int PULSE_W   = 12;
	localparam int TIME_W    = 32;
	localparam int DZ_W      = 7;
	localparam int SEL_W     = 3;
	localparam int REG_IDX_W = 3;

	// timing limits in microseconds
	localparam int SYNC_GAP_US = 3000;
	localparam int CHECK_MIN   = 800;
	localparam int CHECK_MAX   = 2200;
	localparam int PULSE_MIN   = 1000;
	localparam int PULSE_MAX   = 2000;
	localparam int STICK_BIAS  = 100;

	// floor(x / 5) = (x * 205) >> 10 for x in 0..1000
	localparam int STICK_RECIP = 205;
	localparam int STICK_SHIFT = 10;
	// floor(x * 255 / 1000) = (x * 267387) >> 20 for x in 0..1000
	localparam int BYTE_RECIP  = 267387;
	localparam int BYTE_SHIFT  = 20;

	// register indexes on the write port
	localparam logic [REG_IDX_W-1:0] REG_DEADZONE = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_THR_SLOT = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_STR_SLOT = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_MODE_SLOT = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_SPD_SLOT = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_TIMEOUT = 3'd5;

	// request codes
	localparam logic REQ_EDGE    = 1'b0;
	localparam logic REQ_TIMEOUT = 1'b1;

	// result status codes
	localparam logic [1:0] ST_VALID   = 2'd0;
	localparam logic [1:0] ST_LOST    = 2'd1;
	localparam logic [1:0] ST_TIMEOUT = 2'd2;

	typedef enum logic [1:0] {
		ROLE_THR  = 2'd0,
		ROLE_STR  = 2'd1,
		ROLE_MODE = 2'd2,
		ROLE_SPD  = 2'd3
	} role_t;

	typedef logic [PULSE_W-1:0] pulse_t;

	// store request from the edge logic
	typedef struct packed {
		logic   wr;
		logic   sync;
		pulse_t data;
	} store_req_t;

	// reload of one role's pulse after its slot register is written
	typedef struct packed {
		logic             valid;
		role_t            role;
		logic [SEL_W-1:0] sel;
	} reload_t;

	typedef struct packed {
		logic [SEL_W-1:0] thr;
		logic [SEL_W-1:0] str;
		logic [SEL_W-1:0] mode;
		logic [SEL_W-1:0] spd;
	} slot_sel_t;

	typedef struct packed {
		logic   frame_ok;
		pulse_t thr;
		pulse_t str;
		pulse_t mode;
		pulse_t spd;
	} slot_view_t;

	// clamp to 1000..2000 and remove the offset
	function automatic logic [9:0] pulse_offset(input pulse_t p);
		pulse_t c;
		if (p < PULSE_W'(PULSE_MIN))
			c = PULSE_W'(PULSE_MIN);
		else if (p > PULSE_W'(PULSE_MAX))
			c = PULSE_W'(PULSE_MAX);
		else
			c = p;
		return 10'(c - PULSE_W'(PULSE_MIN));
	endfunction

	function automatic logic signed [7:0] to_stick(input pulse_t p, input logic [DZ_W-1:0] dz);
		logic [17:0]       prod;
		logic [7:0]        q;
		logic signed [8:0] r;
		logic [7:0]        mag;
		prod = 18'(pulse_offset(p)) * 18'(STICK_RECIP);
		q    = prod[STICK_SHIFT+7:STICK_SHIFT];
		r    = $signed({1'b0, q}) - 9'(STICK_BIAS);
		mag  = (r < 0) ? 8'(-r) : 8'(r);
		if (mag < {1'b0, dz})
			return 8'sd0;
		return 8'(r);
	endfunction

	function automatic logic [7:0] to_byte(input pulse_t p);
		logic [28:0] prod;
		prod = 29'(pulse_offset(p)) * 29'(BYTE_RECIP);
		return prod[BYTE_SHIFT+7:BYTE_SHIFT];
	endfunction

endpackage

// ----- design/ppmfd_slots.sv -----
// channel pulse store, slot counter, per-role pulse copies and frame check
module ppmfd_slots (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ppmfd_pkg::store_req_t  req,
	input  ppmfd_pkg::reload_t     reload,
	input  ppmfd_pkg::slot_sel_t   sel,
	output ppmfd_pkg::slot_view_t  view
);

	ppmfd_pkg::pulse_t              store_q [ppmfd_pkg::NUM_SLOTS];
	logic [ppmfd_pkg::CNT_W-1:0]    cnt_q;
	ppmfd_pkg::pulse_t              thr_q;
	ppmfd_pkg::pulse_t              str_q;
	ppmfd_pkg::pulse_t              mode_q;
	ppmfd_pkg::pulse_t              spd_q;

	logic                           room;
	logic                           do_wr;
	logic [ppmfd_pkg::SLOT_W-1:0]   wr_idx;
	logic [ppmfd_pkg::SLOT_W-1:0]   rl_idx;
	ppmfd_pkg::pulse_t              rl_data;

	assign room   = 32'(cnt_q) < ppmfd_pkg::NUM_SLOTS;
	assign do_wr  = req.wr && !req.sync && room;
	assign wr_idx = cnt_q[ppmfd_pkg::SLOT_W-1:0];
	assign rl_idx = ppmfd_pkg::SLOT_W'(reload.sel);
	// a slot number past the store reads as zero
	assign rl_data = (32'(reload.sel) < ppmfd_pkg::NUM_SLOTS) ? store_q[rl_idx] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ppmfd_pkg::NUM_SLOTS; i++)
				store_q[i] <= '0;
			cnt_q <= '0;
		end else if (req.sync) begin
			cnt_q <= '0;
		end else if (do_wr) begin
			store_q[wr_idx] <= req.data;
			cnt_q           <= cnt_q + 1'b1;
		end
	end

	// copies track the slot each role reads, so only the reload path needs a wide read mux
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= '0;
			str_q  <= '0;
			mode_q <= '0;
			spd_q  <= '0;
		end else if (do_wr) begin
			if (32'(cnt_q) == 32'(sel.thr))
				thr_q <= req.data;
			if (32'(cnt_q) == 32'(sel.str))
				str_q <= req.data;
			if (32'(cnt_q) == 32'(sel.mode))
				mode_q <= req.data;
			if (32'(cnt_q) == 32'(sel.spd))
				spd_q <= req.data;
		end else if (reload.valid) begin
			case (reload.role)
				ppmfd_pkg::ROLE_THR:  thr_q  <= rl_data;
				ppmfd_pkg::ROLE_STR:  str_q  <= rl_data;
				ppmfd_pkg::ROLE_MODE: mode_q <= rl_data;
				ppmfd_pkg::ROLE_SPD:  spd_q  <= rl_data;
				default:              thr_q  <= rl_data;
			endcase
		end
	end

	always_comb begin
		view.frame_ok = 1'b1;
		for (int i = 0; i < 4; i++) begin
			if (store_q[i] < ppmfd_pkg::PULSE_W'(ppmfd_pkg::CHECK_MIN) ||
			    store_q[i] > ppmfd_pkg::PULSE_W'(ppmfd_pkg::CHECK_MAX))
				view.frame_ok = 1'b0;
		end
		view.thr  = thr_q;
		view.str  = str_q;
		view.mode = mode_q;
		view.spd  = spd_q;
	end

endmodule

// ----- design/ppm_frame_decoder_top.sv -----
// top level of the ppm frame decoder: input register, frame logic, result register
//
//  channel  signals                        transaction
//  -------  -----------------------------  ---------------------------------
//  in       in_valid/in_ready              req_type, time_us
//  out      out_valid/out_ready            throttle, steering, mode, speed, status
//  config   wr_en (no handshake)           wr_index, wr_data
//
// an accepted transaction sits in the input register and is decoded there; its result
// lands in the result register, which drives out_valid, once that register is free.
// one transaction per cycle is sustained; the input register holds only while
// an unread result blocks the result register.
// reset clears all state but the input register's payload at once, no clearing pass.
module ppm_frame_decoder_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 req_type,
	input  logic [ppmfd_pkg::TIME_W-1:0]         time_us,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [7:0]                    throttle,
	output logic signed [7:0]                    steering,
	output logic [7:0]                           mode,
	output logic [7:0]                           speed,
	output logic [1:0]                           status,
	input  logic                                 wr_en,
	input  logic [ppmfd_pkg::REG_IDX_W-1:0]      wr_index,
	input  logic [ppmfd_pkg::TIME_W-1:0]         wr_data
);

	// configuration
	logic [ppmfd_pkg::DZ_W-1:0]   deadzone_q;
	ppmfd_pkg::slot_sel_t         sel_q;
	logic [ppmfd_pkg::TIME_W-1:0] timeout_q;

	// input register
	logic                         valid_s1;
	logic                         req_s1;
	logic [ppmfd_pkg::TIME_W-1:0] time_s1;

	// decoder state
	logic [ppmfd_pkg::TIME_W-1:0] last_edge_q;
	logic [ppmfd_pkg::TIME_W-1:0] last_valid_q;
	logic signed [7:0]            held_thr_q;
	logic signed [7:0]            held_str_q;
	logic [7:0]                   held_mode_q;
	logic [7:0]                   held_spd_q;
	logic                         out_valid_q;
	logic [1:0]                   status_q;

	logic                         adv;
	logic                         proc;
	logic [ppmfd_pkg::TIME_W-1:0] interval;
	logic [ppmfd_pkg::TIME_W-1:0] elapsed;
	logic                         is_sync;
	logic                         expired;
	logic                         has_res;
	logic                         frame_good;
	logic [1:0]                   st_nxt;
	logic signed [7:0]            thr_nxt;
	logic signed [7:0]            str_nxt;
	logic [7:0]                   mode_nxt;
	logic [7:0]                   spd_nxt;

	ppmfd_pkg::store_req_t        store_req;
	ppmfd_pkg::reload_t           reload;
	ppmfd_pkg::slot_view_t        view;

	ppmfd_slots u_slots (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (store_req),
		.reload (reload),
		.sel    (sel_q),
		.view   (view)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadzone_q <= ppmfd_pkg::DZ_W'(5);
			sel_q.thr  <= 3'd0;
			sel_q.str  <= 3'd1;
			sel_q.mode <= 3'd2;
			sel_q.spd  <= 3'd3;
			timeout_q  <= ppmfd_pkg::TIME_W'(500000);
		end else if (wr_en) begin
			case (wr_index)
				ppmfd_pkg::REG_DEADZONE:  deadzone_q <= wr_data[ppmfd_pkg::DZ_W-1:0];
				ppmfd_pkg::REG_THR_SLOT:  sel_q.thr  <= wr_data[ppmfd_pkg::SEL_W-1:0];
				ppmfd_pkg::REG_STR_SLOT:  sel_q.str  <= wr_data[ppmfd_pkg::SEL_W-1:0];
				ppmfd_pkg::REG_MODE_SLOT: sel_q.mode <= wr_data[ppmfd_pkg::SEL_W-1:0];
				ppmfd_pkg::REG_SPD_SLOT:  sel_q.spd  <= wr_data[ppmfd_pkg::SEL_W-1:0];
				ppmfd_pkg::REG_TIMEOUT:   timeout_q  <= wr_data;
				default: ;
			endcase
		end
	end

	// a slot register write refreshes that role's pulse copy unless a pulse is stored at the same time
	always_comb begin
		reload.valid = wr_en;
		reload.sel   = wr_data[ppmfd_pkg::SEL_W-1:0];
		case (wr_index)
			ppmfd_pkg::REG_THR_SLOT:  reload.role = ppmfd_pkg::ROLE_THR;
			ppmfd_pkg::REG_STR_SLOT:  reload.role = ppmfd_pkg::ROLE_STR;
			ppmfd_pkg::REG_MODE_SLOT: reload.role = ppmfd_pkg::ROLE_MODE;
			ppmfd_pkg::REG_SPD_SLOT:  reload.role = ppmfd_pkg::ROLE_SPD;
			default: begin
				reload.valid = 1'b0;
				reload.role  = ppmfd_pkg::ROLE_THR;
			end
		endcase
	end

	assign adv      = !out_valid_q || out_ready;
	assign proc     = valid_s1 && adv;
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1  <= req_type;
			time_s1 <= time_us;
		end
	end

	assign interval   = time_s1 - last_edge_q;
	assign elapsed    = time_s1 - last_valid_q;
	assign is_sync    = interval > ppmfd_pkg::TIME_W'(ppmfd_pkg::SYNC_GAP_US);
	assign expired    = elapsed > timeout_q;
	assign frame_good = view.frame_ok;

	always_comb begin
		has_res        = 1'b0;
		st_nxt         = ppmfd_pkg::ST_VALID;
		thr_nxt        = held_thr_q;
		str_nxt        = held_str_q;
		mode_nxt       = held_mode_q;
		spd_nxt        = held_spd_q;
		store_req.wr   = 1'b0;
		store_req.sync = 1'b0;
		store_req.data = interval[ppmfd_pkg::PULSE_W-1:0];
		if (proc) begin
			if (req_s1 == ppmfd_pkg::REQ_TIMEOUT) begin
				if (expired) begin
					has_res = 1'b1;
					st_nxt  = ppmfd_pkg::ST_TIMEOUT;
					thr_nxt = 8'sd0;
					str_nxt = 8'sd0;
				end
			end else if (is_sync) begin
				store_req.sync = 1'b1;
				has_res        = 1'b1;
				if (!frame_good) begin
					st_nxt  = ppmfd_pkg::ST_LOST;
					thr_nxt = 8'sd0;
					str_nxt = 8'sd0;
				end else begin
					thr_nxt  = ppmfd_pkg::to_stick(view.thr, deadzone_q);
					str_nxt  = ppmfd_pkg::to_stick(view.str, deadzone_q);
					mode_nxt = ppmfd_pkg::to_byte(view.mode);
					spd_nxt  = ppmfd_pkg::to_byte(view.spd);
				end
			end else begin
				store_req.wr = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_edge_q  <= '0;
			last_valid_q <= '0;
			held_thr_q   <= 8'sd0;
			held_str_q   <= 8'sd0;
			held_mode_q  <= 8'd128;
			held_spd_q   <= 8'd128;
			out_valid_q  <= 1'b0;
			status_q     <= ppmfd_pkg::ST_VALID;
		end else begin
			if (proc) begin
				out_valid_q <= has_res;
				if (req_s1 == ppmfd_pkg::REQ_EDGE)
					last_edge_q <= time_s1;
				if (req_s1 == ppmfd_pkg::REQ_EDGE && is_sync && frame_good)
					last_valid_q <= time_s1;
				if (has_res) begin
					status_q    <= st_nxt;
					held_thr_q  <= thr_nxt;
					held_str_q  <= str_nxt;
					held_mode_q <= mode_nxt;
					held_spd_q  <= spd_nxt;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// held commands only change when a new result is loaded, so they are the payload
	assign out_valid = out_valid_q;
	assign throttle  = held_thr_q;
	assign steering  = held_str_q;
	assign mode      = held_mode_q;
	assign speed     = held_spd_q;
	assign status    = status_q;

	a_lost_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ppmfd_pkg::ST_VALID |-> throttle == 8'sd0 && steering == 8'sd0)
		else $error("lost or timeout result with nonzero stick");

	a_stick_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> throttle >= -8'sd100 && throttle <= 8'sd100 &&
		steering >= -8'sd100 && steering <= 8'sd100)
		else $error("stick command out of range");

	a_valid_time: assert property (@(posedge clk) disable iff (!arst_n)
		proc && has_res && st_nxt == ppmfd_pkg::ST_VALID |=> last_valid_q == $past(time_s1))
		else $error("valid frame did not record its time");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(valid_s1))
		else $error("result without a transaction in the input register");

endmodule

// ----- tb/sv/ppm_frame_decoder_checker.sv -----
// checker for the ppm frame decoder: tracks frames and timeouts, compares every command result
`timescale 1ns / 100ps

module ppm_frame_decoder_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  logic                            req_type,
	input  logic [ppmfd_pkg::TIME_W-1:0]    time_us,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  logic signed [7:0]               throttle,
	input  logic signed [7:0]               steering,
	input  logic [7:0]                      mode,
	input  logic [7:0]                      speed,
	input  logic [1:0]                      status,
	input  logic                            wr_en,
	input  logic [ppmfd_pkg::REG_IDX_W-1:0] wr_index,
	input  logic [ppmfd_pkg::TIME_W-1:0]    wr_data,
	output int                              results_due,
	output int                              fail_count
);
	import ppmfd_pkg::*;

	typedef struct packed {
		logic signed [7:0] thr;
		logic signed [7:0] str;
		logic [7:0]        mode;
		logic [7:0]        spd;
		logic [1:0]        st;
	} command_t;

	command_t command_q[$];
	int       mismatches;

	logic [DZ_W-1:0]    dz_cfg;
	logic [SEL_W-1:0]   thr_sel;
	logic [SEL_W-1:0]   str_sel;
	logic [SEL_W-1:0]   mode_sel;
	logic [SEL_W-1:0]   spd_sel;
	logic [TIME_W-1:0]  timeout_cfg;

	logic [TIME_W-1:0]  prev_edge_t;
	int unsigned        chan_idx;
	logic [PULSE_W-1:0] chan_us [NUM_SLOTS];
	logic [TIME_W-1:0]  valid_frame_t;
	command_t           held;

	function automatic int clamp_us(input logic [PULSE_W-1:0] p);
		int v;
		v = int'(p);
		if (v < PULSE_MIN)
			v = PULSE_MIN;
		else if (v > PULSE_MAX)
			v = PULSE_MAX;
		return v;
	endfunction

	// truncating map to -100..100, small magnitudes snap to center
	function automatic logic signed [7:0] stick_of(input logic [PULSE_W-1:0] p);
		int r;
		int mag;
		r   = (clamp_us(p) - PULSE_MIN) * 200 / (PULSE_MAX - PULSE_MIN) - STICK_BIAS;
		mag = (r < 0) ? -r : r;
		if (mag < int'(dz_cfg))
			r = 0;
		return 8'(r);
	endfunction

	function automatic logic [7:0] byte_of(input logic [PULSE_W-1:0] p);
		return 8'((clamp_us(p) - PULSE_MIN) * 255 / (PULSE_MAX - PULSE_MIN));
	endfunction

	function automatic void track_request(input logic rq, input logic [TIME_W-1:0] t);
		logic [TIME_W-1:0] gap;
		logic              frame_ok;
		int                i;
		if (rq == REQ_TIMEOUT) begin
			gap = t - valid_frame_t;
			if (gap > timeout_cfg) begin
				held.thr = '0;
				held.str = '0;
				held.st  = ST_TIMEOUT;
				command_q.push_back(held);
			end
		end else begin
			gap         = t - prev_edge_t;
			prev_edge_t = t;
			if (gap > SYNC_GAP_US) begin
				chan_idx = 0;
				frame_ok = 1'b1;
				for (i = 0; i < 4; i++)
					if (chan_us[i] < CHECK_MIN || chan_us[i] > CHECK_MAX)
						frame_ok = 1'b0;
				if (!frame_ok) begin
					// signal lost: sticks drop, mode and speed stay
					held.thr = '0;
					held.str = '0;
					held.st  = ST_LOST;
				end else begin
					valid_frame_t = t;
					held.thr  = stick_of(chan_us[thr_sel]);
					held.str  = stick_of(chan_us[str_sel]);
					held.mode = byte_of(chan_us[mode_sel]);
					held.spd  = byte_of(chan_us[spd_sel]);
					held.st   = ST_VALID;
				end
				command_q.push_back(held);
			end else if (chan_idx < NUM_SLOTS) begin
				chan_us[chan_idx] = gap[PULSE_W-1:0];
				chan_idx++;
			end
		end
	endfunction

	function automatic void note_failure(input command_t want, input command_t got,
		input logic unexpected);
		if (mismatches < 10) begin
			if (unexpected) begin
				$display("%0t: unexpected result thr %0d str %0d mode %0d spd %0d status %0d",
					$time, got.thr, got.str, got.mode, got.spd, got.st);
			end else begin
				$display("%0t: mismatch exp thr %0d str %0d mode %0d spd %0d status %0d",
					$time, want.thr, want.str, want.mode, want.spd, want.st);
				$display("%0t:          got thr %0d str %0d mode %0d spd %0d status %0d",
					$time, got.thr, got.str, got.mode, got.spd, got.st);
			end
		end
		mismatches++;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		command_t want;
		command_t got;
		int       i;
		if (!arst_n) begin
			dz_cfg        = 7'd5;
			thr_sel       = 3'd0;
			str_sel       = 3'd1;
			mode_sel      = 3'd2;
			spd_sel       = 3'd3;
			timeout_cfg   = 32'd500000;
			prev_edge_t   = '0;
			chan_idx      = 0;
			for (i = 0; i < NUM_SLOTS; i++)
				chan_us[i] = '0;
			valid_frame_t = '0;
			held          = '{thr: 8'sd0, str: 8'sd0, mode: 8'd128, spd: 8'd128, st: ST_VALID};
			command_q.delete();
			mismatches    = 0;
			results_due  <= 0;
			fail_count   <= 0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_DEADZONE:  dz_cfg      = wr_data[DZ_W-1:0];
					REG_THR_SLOT:  thr_sel     = wr_data[SEL_W-1:0];
					REG_STR_SLOT:  str_sel     = wr_data[SEL_W-1:0];
					REG_MODE_SLOT: mode_sel    = wr_data[SEL_W-1:0];
					REG_SPD_SLOT:  spd_sel     = wr_data[SEL_W-1:0];
					REG_TIMEOUT:   timeout_cfg = wr_data;
					default: ;
				endcase
			end
			// results always trail their request, so check before predicting
			if (out_valid && out_ready) begin
				got = '{thr: throttle, str: steering, mode: mode, spd: speed, st: status};
				if (command_q.size() == 0) begin
					note_failure(got, got, 1'b1);
				end else begin
					want = command_q.pop_front();
					if (want.thr !== got.thr || want.str !== got.str || want.mode !== got.mode
						|| want.spd !== got.spd || want.st !== got.st)
						note_failure(want, got, 1'b0);
				end
			end
			if (in_valid && in_ready)
				track_request(req_type, time_us);
			results_due <= command_q.size();
			fail_count  <= mismatches;
		end
	end

endmodule

// ----- tb/sv/tb_ppm_frame_decoder_top.sv -----
// testbench top of the ppm frame decoder: pulse trains, timeout checks, config phases, verdict
`timescale 1ns / 100ps

module tb_ppm_frame_decoder_top;
	import ppmfd_pkg::*;

	localparam int STALL_LIMIT = 2000;

	typedef enum int {
		RDY_ALWAYS,
		RDY_HALF,
		RDY_SPARSE,
		RDY_WAVE
	} ready_mode_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	logic                 req_type  = REQ_EDGE;
	logic [TIME_W-1:0]    time_us   = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic signed [7:0]    throttle;
	logic signed [7:0]    steering;
	logic [7:0]           mode;
	logic [7:0]           speed;
	logic [1:0]           status;
	logic                 wr_en     = 1'b0;
	logic [REG_IDX_W-1:0] wr_index  = REG_DEADZONE;
	logic [TIME_W-1:0]    wr_data   = '0;

	int results_due;
	int fail_count;

	logic [TIME_W-1:0] now_t   = '0;
	logic [TIME_W-1:0] sync_t  = '0;
	logic [TIME_W-1:0] tmo_now = 32'd500000;
	int                burst_left = 0;
	int                sent       = 0;
	int                idle_cycles = 0;
	ready_mode_t       ready_mode  = RDY_ALWAYS;
	int                ready_left  = 0;

	always #10 clk = ~clk;

	ppm_frame_decoder_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.time_us   (time_us),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.throttle  (throttle),
		.steering  (steering),
		.mode      (mode),
		.speed     (speed),
		.status    (status),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data)
	);

	ppm_frame_decoder_checker cmd_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.time_us     (time_us),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.throttle    (throttle),
		.steering    (steering),
		.mode        (mode),
		.speed       (speed),
		.status      (status),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data),
		.results_due (results_due),
		.fail_count  (fail_count)
	);

	// receiver stalls: stretches of different patterns
	always @(posedge clk) begin
		if (arst_n) begin
			if (ready_left == 0) begin
				ready_mode <= ready_mode_t'($urandom_range(0, 3));
				ready_left <= $urandom_range(16, 96);
			end else
				ready_left <= ready_left - 1;
			case (ready_mode)
				RDY_ALWAYS: out_ready <= 1'b1;
				RDY_HALF:   out_ready <= 1'($urandom_range(0, 1));
				RDY_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
				default:    out_ready <= ready_left[3];
			endcase
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else if (idle_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	// one request transaction, with bursts and gaps on the sender side
	task automatic offer(input logic rq, input logic [TIME_W-1:0] t);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		in_valid <= 1'b1;
		req_type <= rq;
		time_us  <= t;
		do @(posedge clk); while (!in_ready);
		sent++;
	endtask

	task automatic send_edge(input logic [TIME_W-1:0] interval);
		now_t = now_t + interval;
		if (interval > SYNC_GAP_US)
			sync_t = now_t;
		offer(REQ_EDGE, now_t);
	endtask

	function automatic logic [TIME_W-1:0] pick_pulse();
		case ($urandom_range(0, 19))
			0:       return $urandom_range(0, SYNC_GAP_US);
			1:       return $urandom_range(950, 1050);
			2:       return $urandom_range(1950, 2050);
			3:       return $urandom_range(1480, 1520);
			default: return $urandom_range(CHECK_MIN, CHECK_MAX);
		endcase
	endfunction

	function automatic logic [TIME_W-1:0] pick_sync();
		case ($urandom_range(0, 7))
			0:       return SYNC_GAP_US + 1;
			1:       return $urandom_range(SYNC_GAP_US + 1, 32'hFFFF_FFFF);
			// land just below the wrap point
			2:       return 32'hFFFF_F000 + $urandom_range(0, 32'hFFF) - now_t;
			default: return $urandom_range(SYNC_GAP_US + 1, 20000);
		endcase
	endfunction

	task automatic send_frame(input int chans);
		int i;
		for (i = 0; i < chans; i++)
			send_edge(pick_pulse());
		send_edge(pick_sync());
	endtask

	task automatic check_timeout();
		logic [TIME_W-1:0] t;
		case ($urandom_range(0, 3))
			0:       t = sync_t + tmo_now + $urandom_range(0, 3) - 1;
			1:       t = now_t + $urandom_range(0, SYNC_GAP_US);
			2:       t = $urandom();
			default: t = sync_t + tmo_now + $urandom_range(0, 200000) - 100000;
		endcase
		offer(REQ_TIMEOUT, t);
	endtask

	task automatic random_items(input int count);
		int start;
		int k;
		start = sent;
		while (sent - start < count) begin
			k = $urandom_range(0, 99);
			if (k < 60)
				send_frame($urandom_range(4, 8));
			else if (k < 68)
				send_frame($urandom_range(9, 12));
			else if (k < 78)
				send_frame($urandom_range(0, 3));
			else if (k < 90)
				check_timeout();
			else if (k < 95)
				send_edge($urandom_range(0, SYNC_GAP_US));
			else
				send_edge($urandom());
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		repeat (2) @(posedge clk);
		while (results_due != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_config(input logic [DZ_W-1:0] dz, input logic [SEL_W-1:0] ts,
		input logic [SEL_W-1:0] ss, input logic [SEL_W-1:0] ms, input logic [SEL_W-1:0] ps,
		input logic [TIME_W-1:0] tmo);
		wr_en    <= 1'b1;
		wr_index <= REG_DEADZONE;
		wr_data  <= TIME_W'(dz);
		@(posedge clk);
		wr_index <= REG_THR_SLOT;
		wr_data  <= TIME_W'(ts);
		@(posedge clk);
		wr_index <= REG_STR_SLOT;
		wr_data  <= TIME_W'(ss);
		@(posedge clk);
		wr_index <= REG_MODE_SLOT;
		wr_data  <= TIME_W'(ms);
		@(posedge clk);
		wr_index <= REG_SPD_SLOT;
		wr_data  <= TIME_W'(ps);
		@(posedge clk);
		wr_index <= REG_TIMEOUT;
		wr_data  <= tmo;
		@(posedge clk);
		wr_en <= 1'b0;
		tmo_now = tmo;
	endtask

	initial begin
		logic [TIME_W-1:0] valid_mark;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// first edge is timed from zero; channel limits exactly at the check bounds
		send_edge(1500);
		send_edge(CHECK_MIN);
		send_edge(CHECK_MAX);
		send_edge(2000);
		send_edge(SYNC_GAP_US + 1);
		valid_mark = now_t;
		// sticks to clamp, a 3000 failing the check, a zero interval, then a sync across the wrap
		send_edge(999);
		send_edge(2001);
		send_edge(SYNC_GAP_US);
		send_edge(0);
		send_edge(32'hFFFF_FFFF);
		// timeout exactly at the limit, then expired twice
		offer(REQ_TIMEOUT, valid_mark + tmo_now);
		offer(REQ_TIMEOUT, valid_mark + tmo_now + 1);
		offer(REQ_TIMEOUT, 32'hFFFF_FFFF);
		// deadzone edge around center, slots overflow with ten channels
		send_edge(1520);
		send_edge(1525);
		send_edge(PULSE_MIN);
		send_edge(PULSE_MAX);
		repeat (4) send_edge(1100);
		send_edge(900);
		send_edge(900);
		send_edge(5000);
		drain();

		load_config(7'd0, 3'd7, 3'd6, 3'd5, 3'd4, 32'd0);
		random_items(290);
		drain();
		load_config(7'd100, 3'd0, 3'd0, 3'd0, 3'd0, 32'hFFFF_FFFF);
		random_items(290);
		drain();
		load_config(7'($urandom_range(0, 100)), 3'($urandom()), 3'($urandom()),
			3'($urandom()), 3'($urandom()), 32'd5000);
		random_items(290);
		drain();
		load_config(7'd1, 3'd3, 3'd2, 3'd1, 3'd0, 32'd20000);
		random_items(290);
		drain();
		load_config(7'($urandom_range(0, 100)), 3'($urandom()), 3'($urandom()),
			3'($urandom()), 3'($urandom()), $urandom());
		random_items(290);
		drain();
		load_config(7'd5, 3'd0, 3'd1, 3'd2, 3'd3, 32'd500000);
		random_items(290);
		drain();

		repeat (6) @(posedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
